### hw/rtl/sbam_pkg.sv
// Package for the signed byte ALU: widths, operation codes, the entry that
// passes through the command queue, and the back-end state type.
// No dependencies; every other file imports it.
package sbam_pkg;

  localparam int WIDTH   = 8;                      // operand width
  localparam int CMD_W   = 2;
  localparam int IN_W    = 8;                      // a_value / b_value field width
  localparam int RES_W   = 16;                     // result field width
  localparam int REM_W   = 8;                      // remainder field width
  localparam int PROD_W  = 2 * WIDTH;
  localparam int CNT_W   = $clog2(WIDTH);
  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  // Classified operation as handed from the front end to the back end.
  typedef struct packed {
    cmd_t             cmd;
    logic [WIDTH-1:0] mag_a;   // |a|, unsigned
    logic [WIDTH-1:0] mag_b;   // |b|, unsigned
    logic [WIDTH-1:0] sum;     // wrapped a+b or a-b
    logic             neg_q;   // operand signs differ
    logic             neg_a;   // dividend is negative
    logic             dz;      // divide with zero divisor
  } sbam_entry_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_OUT
  } back_state_t;

endpackage

### hw/rtl/sbam_in_if.sv
// Input channel interface: valid/ready handshake with the operation payload.
// Depends on sbam_pkg for field widths.
interface sbam_in_if;
  import sbam_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic signed [IN_W-1:0]  a_value;
  logic signed [IN_W-1:0]  b_value;

  modport source (output valid, cmd, a_value, b_value, input ready);
  modport sink   (input valid, cmd, a_value, b_value, output ready);
endinterface

### hw/rtl/sbam_out_if.sv
// Result channel interface: valid/ready handshake with the result payload.
// Depends on sbam_pkg for field widths.
interface sbam_out_if;
  import sbam_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [RES_W-1:0]  result;
  logic signed [REM_W-1:0]  remainder;
  logic                     divide_by_zero;

  modport source (output valid, result, remainder, divide_by_zero, input ready);
  modport sink   (input valid, result, remainder, divide_by_zero, output ready);
endinterface

### hw/rtl/sbam_front.sv
// Front end: takes input beats and classifies them into queue entries
// (magnitudes, signs, zero-divisor flag, wrapped sum or difference).
// Depends on sbam_pkg and sbam_in_if.
module sbam_front (
  sbam_in_if.sink              in_ch,
  input  logic                 q_full,
  output logic                 q_push,
  output sbam_pkg::sbam_entry_t q_wdata
);
  import sbam_pkg::*;

  logic [WIDTH-1:0] a;
  logic [WIDTH-1:0] b;
  cmd_t             cmd;

  assign a   = in_ch.a_value[WIDTH-1:0];
  assign b   = in_ch.b_value[WIDTH-1:0];
  assign cmd = cmd_t'(in_ch.cmd);

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  always_comb begin
    q_wdata.cmd   = cmd;
    // The magnitude of the most negative value wraps to itself, which is
    // its correct unsigned magnitude.
    q_wdata.mag_a = a[WIDTH-1] ? (~a + 1'b1) : a;
    q_wdata.mag_b = b[WIDTH-1] ? (~b + 1'b1) : b;
    q_wdata.sum   = (cmd == CMD_SUB) ? (a - b) : (a + b);
    q_wdata.neg_q = a[WIDTH-1] ^ b[WIDTH-1];
    q_wdata.neg_a = a[WIDTH-1];
    q_wdata.dz    = (cmd == CMD_DIV) && (b == '0);
  end

endmodule

### hw/rtl/sbam_queue.sv
// Short command queue between the front and back ends.
// Depends on sbam_pkg for the entry type and depth.
module sbam_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  sbam_pkg::sbam_entry_t wdata,
  output logic                  full,
  input  logic                  pop,
  output logic                  not_empty,
  output sbam_pkg::sbam_entry_t rdata
);
  import sbam_pkg::*;

  sbam_entry_t       mem_r [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign full      = (count_r == QCNT_W'(Q_DEPTH));
  assign not_empty = (count_r != '0);
  assign rdata     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/sbam_back.sv
// Back end: iterative shift-add multiplier and restoring divider sharing the
// bit counter and the mp_r operand register, sign fix-up and the output register.
// Depends on sbam_pkg and sbam_out_if.
module sbam_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_not_empty,
  input  sbam_pkg::sbam_entry_t q_rdata,
  output logic                  q_pop,
  sbam_out_if.source            out_ch
);
  import sbam_pkg::*;

  back_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  sbam_entry_t         ent_r, ent_nxt;
  logic [PROD_W-1:0]   acc_r, acc_nxt;     // product accumulator
  logic [PROD_W-1:0]   mc_r, mc_nxt;       // shifted multiplicand
  logic [WIDTH-1:0]    mp_r, mp_nxt;       // multiplier, or dividend/quotient
  logic [WIDTH-1:0]    rem_r, rem_nxt;     // partial remainder
  logic                out_valid_r, out_valid_nxt;
  logic [RES_W-1:0]    out_res_r, out_res_nxt;
  logic [REM_W-1:0]    out_rem_r, out_rem_nxt;
  logic                out_dz_r, out_dz_nxt;

  logic [WIDTH:0]      div_shift;
  logic [WIDTH:0]      div_diff;
  logic                div_ge;
  logic [PROD_W-1:0]   prod_fix;
  logic [WIDTH-1:0]    quo_fix;
  logic [WIDTH-1:0]    rem_fix;
  logic                out_free;

  assign div_shift = {rem_r, mp_r[WIDTH-1]};
  assign div_ge    = (div_shift >= {1'b0, ent_r.mag_b});
  assign div_diff  = div_shift - {1'b0, ent_r.mag_b};
  assign prod_fix  = ent_r.neg_q ? (~acc_r + 1'b1) : acc_r;
  assign quo_fix   = ent_r.neg_q ? (~mp_r + 1'b1) : mp_r;
  assign rem_fix   = ent_r.neg_a ? (~rem_r + 1'b1) : rem_r;
  assign out_free  = !out_valid_r || out_ch.ready;

  assign out_ch.valid          = out_valid_r;
  assign out_ch.result         = out_res_r;
  assign out_ch.remainder      = out_rem_r;
  assign out_ch.divide_by_zero = out_dz_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ent_nxt       = ent_r;
    acc_nxt       = acc_r;
    mc_nxt        = mc_r;
    mp_nxt        = mp_r;
    rem_nxt       = rem_r;
    out_res_nxt   = out_res_r;
    out_rem_nxt   = out_rem_r;
    out_dz_nxt    = out_dz_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    q_pop         = 1'b0;

    case (state_r)
      BK_IDLE: begin
        if (q_not_empty) begin
          q_pop   = 1'b1;
          ent_nxt = q_rdata;
          cnt_nxt = CNT_W'(WIDTH - 1);
          acc_nxt = '0;
          rem_nxt = '0;
          mc_nxt  = PROD_W'(q_rdata.mag_a);
          mp_nxt  = (q_rdata.cmd == CMD_MUL) ? q_rdata.mag_b : q_rdata.mag_a;
          case (q_rdata.cmd)
            CMD_MUL: state_nxt = BK_MUL;
            CMD_DIV: state_nxt = q_rdata.dz ? BK_OUT : BK_DIV;
            default: state_nxt = BK_OUT;
          endcase
        end
      end
      BK_MUL: begin
        if (mp_r[0]) begin
          acc_nxt = acc_r + mc_r;
        end
        mc_nxt  = {mc_r[PROD_W-2:0], 1'b0};
        mp_nxt  = {1'b0, mp_r[WIDTH-1:1]};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = BK_OUT;
        end
      end
      BK_DIV: begin
        // One quotient bit per cycle, most significant first.
        rem_nxt = div_ge ? div_diff[WIDTH-1:0] : div_shift[WIDTH-1:0];
        mp_nxt  = {mp_r[WIDTH-2:0], div_ge};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = BK_OUT;
        end
      end
      BK_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_dz_nxt    = ent_r.dz;
          out_rem_nxt   = '0;
          case (ent_r.cmd)
            CMD_MUL: out_res_nxt = RES_W'(signed'(prod_fix));
            CMD_DIV: begin
              if (ent_r.dz) begin
                out_res_nxt = '0;
              end else begin
                out_res_nxt = RES_W'(signed'(quo_fix));
                out_rem_nxt = REM_W'(signed'(rem_fix));
              end
            end
            default: out_res_nxt = RES_W'(signed'(ent_r.sum));
          endcase
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r     <= cnt_nxt;
    ent_r     <= ent_nxt;
    acc_r     <= acc_nxt;
    mc_r      <= mc_nxt;
    mp_r      <= mp_nxt;
    rem_r     <= rem_nxt;
    out_res_r <= out_res_nxt;
    out_rem_r <= out_rem_nxt;
    out_dz_r  <= out_dz_nxt;
  end

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == BK_IDLE))
    else $error("queue popped while the back end was busy");

  a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_DIV) |-> (rem_r < ent_r.mag_b))
    else $error("partial remainder not below the divisor");

  a_mul_runs_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_MUL && cnt_r != '0) |=> (state_r == BK_MUL))
    else $error("multiply left before all multiplier bits were used");

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_dz_r) |-> (out_res_r == '0 && out_rem_r == '0))
    else $error("zero-divisor beat carries nonzero results");

endmodule

### hw/rtl/signed_byte_alu_mul_div.sv
// Signed byte ALU: add, subtract, 16-bit multiply and divide with remainder.
//
// Channels: in_ch carries cmd, a_value and b_value; out_ch carries result,
// remainder and divide_by_zero. Both use valid/ready, a beat moves when both
// are high. One result beat is produced for every input beat, in order.
// Add, subtract and a zero-divisor divide pass from the input beat through
// the queue, the back-end entry register and the output register to
// out_ch.valid; multiply and divide also iterate in the back end first, one
// multiplier or quotient bit per cycle in the shared shift-add /
// restoring-subtract unit. The back end holds one item at a time and pops the
// next only after the last result has gone into the output register.
// A two-entry queue lets the front end keep taking beats while the back end
// iterates or a finished result waits in the output register.
// Reset (rst_n low, synchronous) empties the queue, returns the back end to
// idle and drops out_ch.valid. When the receiver holds out_ch.ready low, the
// result stays on out_ch, the back end waits with the next result, and in_ch
// goes not-ready once the queue fills.
module signed_byte_alu_mul_div (
  input  logic        clk,
  input  logic        rst_n,
  sbam_in_if.sink     in_ch,
  sbam_out_if.source  out_ch
);
  import sbam_pkg::*;

  sbam_entry_t q_wdata;
  sbam_entry_t q_rdata;
  logic        q_push;
  logic        q_pop;
  logic        q_full;
  logic        q_not_empty;

  sbam_front u_front (
    .in_ch   (in_ch),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  sbam_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rdata     (q_rdata)
  );

  sbam_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_rdata     (q_rdata),
    .q_pop       (q_pop),
    .out_ch      (out_ch)
  );

endmodule
